// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, types and status codes of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int BUFFER_BYTES       = 65536;
    localparam int FREE_HEADER_BYTES  = 24;
    localparam int ALLOC_HEADER_BYTES = 8;
    localparam int MAX_FREE_ENTRIES   = 256;
    localparam int MAX_USED_ENTRIES   = 256;

    localparam int OFS_W   = 16;
    localparam int SIZE_W  = 17;
    localparam int FREE_AW = $clog2(MAX_FREE_ENTRIES);
    localparam int USED_AW = $clog2(MAX_USED_ENTRIES);
    localparam int FCNT_W  = FREE_AW + 1;
    localparam int STAT_W  = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NO_FREE = 3'd1,
        ST_NO_FIT  = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [OFS_W-1:0]  start;
        logic [SIZE_W-1:0] size;
    } t_blk;

    typedef struct packed {
        logic              valid;
        logic              action;
        logic [OFS_W-1:0]  request_bytes;
        logic [OFS_W-1:0]  data_offset;
    } t_req;

    typedef struct packed {
        logic              valid;
        logic [OFS_W-1:0]  offset;
        t_status           status;
    } t_res;

    typedef struct packed {
        logic               en;
        logic [FREE_AW-1:0] addr;
        t_blk               data;
    } t_free_wr;

    typedef struct packed {
        logic               en;
        logic [USED_AW-1:0] addr;
        t_blk               data;
    } t_used_wr;

endpackage

// ===== rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer of the allocator: walks the free and used tables one entry per
// cycle, decides the allocate and free cases and shifts the free table.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffa_pkg::t_req                 i_req,
    output logic                          o_ready,
    output ffa_pkg::t_res                 o_res,
    input  logic                          i_res_take,
    output ffa_pkg::t_free_wr             o_free_wr,
    output logic [ffa_pkg::FREE_AW-1:0]   o_free_raddr,
    input  ffa_pkg::t_blk                 i_free_rdata,
    output ffa_pkg::t_used_wr             o_used_wr,
    output logic [ffa_pkg::USED_AW-1:0]   o_used_raddr,
    input  ffa_pkg::t_blk                 i_used_rdata
);
    import ffa_pkg::*;

    typedef enum logic [10:0] {
        S_INIT   = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_AFIND  = 11'b000_0000_0100,
        S_AUSED  = 11'b000_0000_1000,
        S_FUSED  = 11'b000_0001_0000,
        S_FNEIGH = 11'b000_0010_0000,
        S_FAPPLY = 11'b000_0100_0000,
        S_RMVS   = 11'b000_1000_0000,
        S_RMV    = 11'b001_0000_0000,
        S_INS    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [FCNT_W-1:0]     r_count, n_count;
    logic [FCNT_W-1:0]     r_fidx, n_fidx;
    logic [USED_AW-1:0]    r_uidx, n_uidx;
    logic [MAX_USED_ENTRIES-1:0] r_valid, n_valid;
    logic [SIZE_W-1:0]     r_need, n_need;
    logic [OFS_W-1:0]      r_off, n_off;
    logic [OFS_W-1:0]      r_bs, n_bs;
    logic [SIZE_W-1:0]     r_bz, n_bz;
    logic [SIZE_W-1:0]     r_spare, n_spare;
    logic                  r_whole, n_whole;
    logic [FCNT_W-1:0]     r_hit, n_hit;
    logic [FCNT_W-1:0]     r_left, n_left;
    logic [OFS_W-1:0]      r_lstart, n_lstart;
    logic [SIZE_W-1:0]     r_lsize, n_lsize;
    logic [SIZE_W-1:0]     r_rsize, n_rsize;
    logic                  r_hasl, n_hasl;
    logic                  r_hasr, n_hasr;
    logic [USED_AW-1:0]    r_uhit, n_uhit;
    logic [OFS_W-1:0]      r_res_off, n_res_off;
    t_status               r_status, n_status;

    logic [SIZE_W-1:0]     spare;
    logic                  whole;
    logic [SIZE_W-1:0]     bstart;
    logic [SIZE_W-1:0]     aoff;
    logic [SIZE_W-1:0]     fend;
    logic [SIZE_W-1:0]     bend;
    logic [SIZE_W-1:0]     uoff;

    // Candidate arithmetic for the entry currently on the read port.
    always_comb begin
        spare  = i_free_rdata.size - r_need;
        whole  = spare < SIZE_W'(FREE_HEADER_BYTES);
        bstart = whole ? {1'b0, i_free_rdata.start}
                       : {1'b0, i_free_rdata.start} + spare;
        aoff   = bstart + SIZE_W'(ALLOC_HEADER_BYTES);
        fend   = {1'b0, i_free_rdata.start} + i_free_rdata.size;
        bend   = {1'b0, r_bs} + r_bz;
        uoff   = {1'b0, i_used_rdata.start} + SIZE_W'(ALLOC_HEADER_BYTES);
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_fidx    = r_fidx;
        n_uidx    = r_uidx;
        n_valid   = r_valid;
        n_need    = r_need;
        n_off     = r_off;
        n_bs      = r_bs;
        n_bz      = r_bz;
        n_spare   = r_spare;
        n_whole   = r_whole;
        n_hit     = r_hit;
        n_left    = r_left;
        n_lstart  = r_lstart;
        n_lsize   = r_lsize;
        n_rsize   = r_rsize;
        n_hasl    = r_hasl;
        n_hasr    = r_hasr;
        n_uhit    = r_uhit;
        n_res_off = r_res_off;
        n_status  = r_status;
        o_free_wr = '0;
        o_used_wr = '0;

        unique case (r_state)
            S_INIT: begin
                o_free_wr.en   = 1'b1;
                o_free_wr.addr = '0;
                o_free_wr.data = '{start: '0, size: SIZE_W'(BUFFER_BYTES)};
                n_count        = FCNT_W'(1);
                n_state        = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_need    = {1'b0, i_req.request_bytes} + SIZE_W'(ALLOC_HEADER_BYTES);
                    n_off     = i_req.data_offset;
                    n_res_off = '0;
                    n_fidx    = '0;
                    n_uidx    = '0;
                    if (i_req.action == ACT_FREE) begin
                        n_state = S_FUSED;
                    end else if (r_count == '0) begin
                        n_status = ST_NO_FREE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_AFIND;
                    end
                end
            end
            S_AFIND: begin
                if (i_free_rdata.size >= r_need) begin
                    n_hit     = r_fidx;
                    n_spare   = spare;
                    n_whole   = whole;
                    n_bs      = bstart[OFS_W-1:0];
                    n_bz      = whole ? i_free_rdata.size : r_need;
                    n_lstart  = i_free_rdata.start;
                    n_res_off = aoff[OFS_W-1:0];
                    n_uidx    = '0;
                    if (aoff[SIZE_W-1]) begin
                        n_res_off = '0;
                        n_status  = ST_NO_FIT;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_AUSED;
                    end
                end else if (r_fidx + FCNT_W'(1) == r_count) begin
                    n_status = ST_NO_FIT;
                    n_state  = S_DONE;
                end else begin
                    n_fidx = r_fidx + FCNT_W'(1);
                end
            end
            S_AUSED: begin
                if (!r_valid[r_uidx]) begin
                    o_used_wr.en   = 1'b1;
                    o_used_wr.addr = r_uidx;
                    o_used_wr.data = '{start: r_bs, size: r_bz};
                    n_valid[r_uidx] = 1'b1;
                    n_status       = ST_OK;
                    if (r_whole) begin
                        n_fidx  = r_hit;
                        n_state = S_RMVS;
                    end else begin
                        o_free_wr.en   = 1'b1;
                        o_free_wr.addr = r_hit[FREE_AW-1:0];
                        o_free_wr.data = '{start: r_lstart, size: r_spare};
                        n_state        = S_DONE;
                    end
                end else if (r_uidx == USED_AW'(MAX_USED_ENTRIES - 1)) begin
                    n_res_off = '0;
                    n_status  = ST_FULL;
                    n_state   = S_DONE;
                end else begin
                    n_uidx = r_uidx + USED_AW'(1);
                end
            end
            S_FUSED: begin
                if (r_valid[r_uidx] && uoff == {1'b0, r_off}) begin
                    n_bs   = i_used_rdata.start;
                    n_bz   = i_used_rdata.size;
                    n_uhit = r_uidx;
                    n_hasl = 1'b0;
                    n_hasr = 1'b0;
                    n_fidx = '0;
                    if (r_count == '0) begin
                        o_free_wr.en    = 1'b1;
                        o_free_wr.addr  = '0;
                        o_free_wr.data  = i_used_rdata;
                        n_count         = FCNT_W'(1);
                        n_valid[r_uidx] = 1'b0;
                        n_status        = ST_OK;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_FNEIGH;
                    end
                end else if (r_uidx == USED_AW'(MAX_USED_ENTRIES - 1)) begin
                    n_status = ST_UNKNOWN;
                    n_state  = S_DONE;
                end else begin
                    n_uidx = r_uidx + USED_AW'(1);
                end
            end
            S_FNEIGH: begin
                // Later matches override earlier ones on each side.
                if (fend == {1'b0, r_bs}) begin
                    n_hasl   = 1'b1;
                    n_left   = r_fidx;
                    n_lstart = i_free_rdata.start;
                    n_lsize  = i_free_rdata.size;
                end
                if (bend == {1'b0, i_free_rdata.start}) begin
                    n_hasr  = 1'b1;
                    n_hit   = r_fidx;
                    n_rsize = i_free_rdata.size;
                end
                if (r_fidx + FCNT_W'(1) == r_count) begin
                    n_state = S_FAPPLY;
                end else begin
                    n_fidx = r_fidx + FCNT_W'(1);
                end
            end
            S_FAPPLY: begin
                n_status = ST_OK;
                priority if (!r_hasl && !r_hasr) begin
                    if (r_count >= FCNT_W'(MAX_FREE_ENTRIES)) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_fidx  = r_count - FCNT_W'(1);
                        n_state = S_INS;
                    end
                end else if (!r_hasl) begin
                    o_free_wr.en   = 1'b1;
                    o_free_wr.addr = r_hit[FREE_AW-1:0];
                    o_free_wr.data = '{start: r_bs, size: r_rsize + r_bz};
                    n_valid[r_uhit] = 1'b0;
                    n_state        = S_DONE;
                end else if (!r_hasr) begin
                    o_free_wr.en   = 1'b1;
                    o_free_wr.addr = r_left[FREE_AW-1:0];
                    o_free_wr.data = '{start: r_lstart, size: r_lsize + r_bz};
                    n_valid[r_uhit] = 1'b0;
                    n_state        = S_DONE;
                end else begin
                    o_free_wr.en   = 1'b1;
                    o_free_wr.addr = r_left[FREE_AW-1:0];
                    o_free_wr.data = '{start: r_lstart, size: r_lsize + r_bz + r_rsize};
                    n_valid[r_uhit] = 1'b0;
                    n_fidx         = r_hit;
                    n_state        = S_RMVS;
                end
            end
            S_RMVS: begin
                // A gap state so that the sweep reads data written just before.
                n_fidx  = r_fidx + FCNT_W'(1);
                n_state = S_RMV;
            end
            S_RMV: begin
                if (r_fidx < r_count) begin
                    o_free_wr.en   = 1'b1;
                    o_free_wr.addr = FREE_AW'(r_fidx - FCNT_W'(1));
                    o_free_wr.data = i_free_rdata;
                    n_fidx         = r_fidx + FCNT_W'(1);
                end else begin
                    n_count = r_count - FCNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                if (r_fidx != '0) begin
                    o_free_wr.en   = 1'b1;
                    o_free_wr.addr = FREE_AW'(r_fidx + FCNT_W'(1));
                    o_free_wr.data = i_free_rdata;
                    n_fidx         = r_fidx - FCNT_W'(1);
                end else begin
                    o_free_wr.en    = 1'b1;
                    o_free_wr.addr  = FREE_AW'(1);
                    o_free_wr.data  = '{start: r_bs, size: r_bz};
                    n_count         = r_count + FCNT_W'(1);
                    n_valid[r_uhit] = 1'b0;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fidx    <= n_fidx;
        r_uidx    <= n_uidx;
        r_need    <= n_need;
        r_off     <= n_off;
        r_bs      <= n_bs;
        r_bz      <= n_bz;
        r_spare   <= n_spare;
        r_whole   <= n_whole;
        r_hit     <= n_hit;
        r_left    <= n_left;
        r_lstart  <= n_lstart;
        r_lsize   <= n_lsize;
        r_rsize   <= n_rsize;
        r_hasl    <= n_hasl;
        r_hasr    <= n_hasr;
        r_uhit    <= n_uhit;
        r_res_off <= n_res_off;
        r_status  <= n_status;
    end

    // Reads are issued with the next index so the data lines up with r_fidx/r_uidx.
    assign o_free_raddr = n_fidx[FREE_AW-1:0];
    assign o_used_raddr = n_uidx;
    assign o_ready      = (r_state == S_IDLE);
    assign o_res        = '{valid: (r_state == S_DONE), offset: r_res_off, status: r_status};

endmodule

// ===== rtl/first_fit_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// First-fit allocator with coalescing over a 64 KiB buffer.
// ----------------------------------------------------------------------------
// One word is handled at a time. After reset the block writes the root entry
// of the free table before it takes a word. An allocate walks the free
// entries until the first fit and then scans the used-table slots for a free
// slot; a whole-block take adds a down-shift of the free table from the taken
// entry to the end of the list. A free scans the used-table slots for the
// match and walks the whole free list for neighbours, then either shifts the
// table up behind the first entry on an insert, or shifts it down from the
// removed entry to the end of the list on a double merge. Both tables are
// walked through their single read port, one entry per cycle. The result
// waits in an output register, so a new word can be accepted while the
// previous result is still pending.
module first_fit_free_list_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic [ffa_pkg::OFS_W-1:0]    i_request_bytes,
    input  logic [ffa_pkg::OFS_W-1:0]    i_data_offset,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ffa_pkg::OFS_W-1:0]    o_result_offset,
    output logic [ffa_pkg::STAT_W-1:0]   o_status
);
    import ffa_pkg::*;

    t_req               req;
    t_res               res;
    logic               ctrl_ready;
    logic               res_take;
    t_free_wr           free_wr;
    t_used_wr           used_wr;
    logic [FREE_AW-1:0] free_raddr;
    logic [USED_AW-1:0] used_raddr;
    t_blk               free_rdata;
    t_blk               used_rdata;

    logic               r_ovalid;
    logic [OFS_W-1:0]   r_ooff;
    logic [STAT_W-1:0]  r_ostat;

    assign req      = '{valid: i_valid, action: i_action,
                        request_bytes: i_request_bytes, data_offset: i_data_offset};
    assign res_take = res.valid && (!r_ovalid || i_ready);

    ffa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_ready      (ctrl_ready),
        .o_res        (res),
        .i_res_take   (res_take),
        .o_free_wr    (free_wr),
        .o_free_raddr (free_raddr),
        .i_free_rdata (free_rdata),
        .o_used_wr    (used_wr),
        .o_used_raddr (used_raddr),
        .i_used_rdata (used_rdata)
    );

    ffa_ram #(.DEPTH(MAX_FREE_ENTRIES), .WIDTH($bits(t_blk))) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_wr.en),
        .i_waddr (free_wr.addr),
        .i_wdata (free_wr.data),
        .i_raddr (free_raddr),
        .o_rdata (free_rdata)
    );

    ffa_ram #(.DEPTH(MAX_USED_ENTRIES), .WIDTH($bits(t_blk))) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_wr.en),
        .i_waddr (used_wr.addr),
        .i_wdata (used_wr.data),
        .i_raddr (used_raddr),
        .o_rdata (used_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_take) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_ooff  <= res.offset;
            r_ostat <= res.status;
        end
    end

    assign o_ready         = ctrl_ready;
    assign o_valid         = r_ovalid;
    assign o_result_offset = r_ooff;
    assign o_status        = r_ostat;

endmodule

// ===== rtl/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ffa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [ffa_pkg::OFS_W-1:0]    o_result_offset,
    input logic [ffa_pkg::STAT_W-1:0]   o_status
);
    import ffa_pkg::*;

    // A pending result must hold until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_offset) && $stable(o_status))
        else $error("result changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= STAT_W'(ST_FULL))
        else $error("undefined status code");

    // Errors and frees never return an offset.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_W'(ST_OK) |-> o_result_offset == '0)
        else $error("offset on error");

    // Every accepted word moves the sequencer out of its idle state, so the input closes after it.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

endmodule

bind first_fit_free_list_allocator_unit ffa_checker u_ffa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_result_offset (o_result_offset),
    .o_status        (o_status)
);

// ===== tb/sv/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_scoreboard
// Watches both channels of the allocator, predicts each result from its own
// copy of the free list and used table, and counts mismatches.
// ----------------------------------------------------------------------------
module ffa_scoreboard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_ready_in,
    input  logic                       i_action,
    input  logic [ffa_pkg::OFS_W-1:0]  i_request_bytes,
    input  logic [ffa_pkg::OFS_W-1:0]  i_data_offset,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [ffa_pkg::OFS_W-1:0]  i_result_offset,
    input  logic [ffa_pkg::STAT_W-1:0] i_status,
    output int                         o_errors,
    output int                         o_pending,
    output logic                       o_accepted
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    typedef struct packed {
        logic [OFS_W-1:0] offset;
        t_status          status;
    } t_answer;

    int unsigned free_start [MAX_FREE_ENTRIES];
    int unsigned free_size  [MAX_FREE_ENTRIES];
    int unsigned free_count;
    int unsigned used_start [MAX_USED_ENTRIES];
    int unsigned used_size  [MAX_USED_ENTRIES];
    bit          used_live  [MAX_USED_ENTRIES];
    t_answer     answers_due[$];

    function automatic void drop_free(int unsigned idx);
        for (int unsigned k = idx; k + 1 < free_count; k++) begin
            free_start[k] = free_start[k+1];
            free_size[k]  = free_size[k+1];
        end
        free_count--;
    endfunction

    function automatic t_answer allocate(int unsigned req);
        int unsigned need, i, u, spare, bstart, bsize, off;
        bit whole;
        need = req + ALLOC_HEADER_BYTES;
        allocate = '{offset: '0, status: ST_OK};
        if (free_count == 0) begin
            allocate.status = ST_NO_FREE;
            return allocate;
        end
        for (i = 0; i < free_count; i++)
            if (free_size[i] >= need) break;
        if (i >= free_count) begin
            allocate.status = ST_NO_FIT;
            return allocate;
        end
        spare = free_size[i] - need;
        whole = spare < FREE_HEADER_BYTES;
        bstart = whole ? free_start[i] : free_start[i] + spare;
        bsize  = whole ? free_size[i] : need;
        off = bstart + ALLOC_HEADER_BYTES;
        if (off > 16'hFFFF) begin
            allocate.status = ST_NO_FIT;
            return allocate;
        end
        for (u = 0; u < MAX_USED_ENTRIES; u++)
            if (!used_live[u]) break;
        if (u >= MAX_USED_ENTRIES) begin
            allocate.status = ST_FULL;
            return allocate;
        end
        if (whole) drop_free(i);
        else free_size[i] = spare;
        used_start[u] = bstart;
        used_size[u]  = bsize;
        used_live[u]  = 1'b1;
        allocate.offset = off[OFS_W-1:0];
    endfunction

    function automatic t_answer release_block(int unsigned off);
        int unsigned u, i, b, s, lft, rgt;
        bit has_l, has_r;
        release_block = '{offset: '0, status: ST_OK};
        lft = 0; rgt = 0; has_l = 0; has_r = 0;
        for (u = 0; u < MAX_USED_ENTRIES; u++)
            if (used_live[u] && used_start[u] + ALLOC_HEADER_BYTES == off) break;
        if (u >= MAX_USED_ENTRIES) begin
            release_block.status = ST_UNKNOWN;
            return release_block;
        end
        b = used_start[u];
        s = used_size[u];
        if (free_count == 0) begin
            free_start[0] = b;
            free_size[0]  = s;
            free_count    = 1;
            used_live[u]  = 1'b0;
            return release_block;
        end
        // The last match in list order wins on each side.
        for (i = 0; i < free_count; i++) begin
            if (free_start[i] + free_size[i] == b) begin lft = i; has_l = 1; end
            if (b + s == free_start[i]) begin rgt = i; has_r = 1; end
        end
        if (!has_l && !has_r) begin
            if (free_count >= MAX_FREE_ENTRIES) begin
                release_block.status = ST_FULL;
                return release_block;
            end
            for (int unsigned k = free_count; k > 1; k--) begin
                free_start[k] = free_start[k-1];
                free_size[k]  = free_size[k-1];
            end
            free_start[1] = b;
            free_size[1]  = s;
            free_count++;
        end else if (!has_l) begin
            free_size[rgt] += s;
            free_start[rgt] = b;
        end else if (!has_r) begin
            free_size[lft] += s;
        end else begin
            free_size[lft] += s + free_size[rgt];
            drop_free(rgt);
        end
        used_live[u] = 1'b0;
    endfunction

    assign o_pending  = answers_due.size();
    assign o_accepted = (i_valid && i_ready_in) || (i_out_valid && i_out_ready);

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_FREE_ENTRIES; k++) begin
                free_start[k] = 0;
                free_size[k]  = 0;
            end
            free_size[0] = BUFFER_BYTES;
            free_count   = 1;
            for (int k = 0; k < MAX_USED_ENTRIES; k++) used_live[k] = 1'b0;
            answers_due.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: result word with nothing expected", $time);
                end else begin
                    want = answers_due.pop_front();
                    if (i_result_offset !== want.offset || i_status !== want.status) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: mismatch offset exp %h got %h, status exp %0d got %0d",
                                     $time, want.offset, i_result_offset,
                                     want.status, i_status);
                    end
                end
            end
            if (i_valid && i_ready_in)
                answers_due.push_back(i_action == ACT_ALLOC ? allocate(i_request_bytes)
                                                            : release_block(i_data_offset));
        end
    end
endmodule

// ===== tb/sv/tb_first_fit_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator_unit
// Drives allocate and free words into the allocator with random idling and
// back-pressure; the scoreboard module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_first_fit_free_list_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    localparam int WATCHDOG_CYCLES = 200000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              in_action = ACT_ALLOC;
    logic [OFS_W-1:0]  in_request = '0;
    logic [OFS_W-1:0]  in_offset = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [OFS_W-1:0]  out_offset;
    logic [STAT_W-1:0] out_status;
    int                errors, pending;
    logic              accepted;
    int                send_idle_pct = 0, recv_stall_pct = 0;
    int                quiet_cycles = 0;
    logic [OFS_W-1:0]  live_offsets[$];

    always #6 clk = ~clk;

    first_fit_free_list_allocator_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_action(in_action), .i_request_bytes(in_request),
        .i_data_offset(in_offset), .o_valid(out_valid), .i_ready(out_ready),
        .o_result_offset(out_offset), .o_status(out_status)
    );

    ffa_scoreboard u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_action(in_action), .i_request_bytes(in_request),
        .i_data_offset(in_offset), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .i_result_offset(out_offset),
        .i_status(out_status), .o_errors(errors), .o_pending(pending),
        .o_accepted(accepted)
    );

    // Successful allocations are learned from the result channel so that
    // most frees target real blocks.
    always @(posedge clk) begin
        if (out_valid && out_ready && out_status == ST_OK && out_offset != 0)
            live_offsets.push_back(out_offset);
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || accepted) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_CYCLES) begin
            $display("FAIL first_fit_free_list_allocator_unit");
            $finish;
        end
    end

    // Each word waits for a fresh falling edge after the previous one was dropped,
    // so valid is never assigned twice in the same time step.
    task automatic send_word(input logic act, input logic [OFS_W-1:0] req,
                             input logic [OFS_W-1:0] off);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid   <= 1'b1;
        in_action  <= act;
        in_request <= req;
        in_offset  <= off;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic free_some(input int pick);
        int idx;
        logic [OFS_W-1:0] off;
        // A directed pick waits until earlier results have been collected.
        if (pick >= 0) begin
            while (pending != 0) @(negedge clk);
        end
        if (live_offsets.size() == 0) begin
            send_word(ACT_FREE, 16'($urandom), 16'($urandom));
        end else begin
            idx = (pick < 0 || pick >= live_offsets.size()) ?
                  $urandom_range(live_offsets.size() - 1) : pick;
            off = live_offsets[idx];
            live_offsets.delete(idx);
            send_word(ACT_FREE, 16'($urandom), off);
        end
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            case ($urandom_range(3))
                0: send_word(ACT_ALLOC, 16'($urandom_range(32)), 16'($urandom));
                1: send_word(ACT_ALLOC, 16'($urandom_range(600)), 16'($urandom));
                2: send_word(ACT_ALLOC, 16'($urandom_range(4000)), 16'($urandom));
                default: send_word(ACT_ALLOC, 16'($urandom), 16'($urandom));
            endcase
        end else if (r < 90) begin
            free_some(-1);
        end else if (r < 95) begin
            send_word(ACT_FREE, 16'($urandom), 16'($urandom));
        end else if (live_offsets.size() > 0) begin
            // A free of a live block's offset with bit 4 flipped.
            send_word(ACT_FREE, 16'($urandom), live_offsets[0] ^ 16'h0010);
        end else begin
            send_word(ACT_ALLOC, 16'hFFFF, 16'hFFFF);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: exact fits, tail cuts, whole-block takes, errors, all merges.
        send_word(ACT_FREE, 16'h0000, 16'h0008);        // unknown free
        send_word(ACT_ALLOC, 16'hFFFF, 16'h0000);       // no fit
        send_word(ACT_ALLOC, 16'd65528, 16'hFFFF);      // whole buffer, list empty
        send_word(ACT_ALLOC, 16'd0, 16'h0000);          // empty free list
        free_some(0);                                    // becomes only entry
        send_word(ACT_ALLOC, 16'd65510, 16'h0000);      // spare below header: whole
        free_some(0);
        send_word(ACT_ALLOC, 16'd100, 16'h0000);
        send_word(ACT_ALLOC, 16'd200, 16'h0000);
        send_word(ACT_ALLOC, 16'd300, 16'h0000);
        send_word(ACT_ALLOC, 16'd0, 16'h0000);
        free_some(1);                                    // middle, no neighbours
        free_some(0);                                    // left neighbour is free
        free_some(1);                                    // left merges
        free_some(0);                                    // both sides
        for (int k = 0; k < 6; k++) send_word(ACT_ALLOC, 16'(k * 7), 16'h0000);
        for (int k = 0; k < 6; k++) free_some(-1);
        send_word(ACT_FREE, 16'hFFFF, 16'hFFFF);

        // Random phases with different idling mixes.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                3: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 60; n++) random_word();
        end

        // Fill the used table to reach the table-full status, then drain.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int n = 0; n < 280; n++) send_word(ACT_ALLOC, 16'($urandom_range(40)), '0);
        while (pending != 0) @(negedge clk);
        while (live_offsets.size() > 0) free_some(-1);

        while (pending != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS first_fit_free_list_allocator_unit");
        end else begin
            $display("FAIL first_fit_free_list_allocator_unit");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/ffa_ctrl.sv
rtl/first_fit_free_list_allocator_unit.sv
rtl/ffa_checker.sv
tb/sv/ffa_checker.sv
tb/sv/tb_first_fit_free_list_allocator_unit.sv
